// File: sv/rss_pkg.sv
// Shared constants and types of the serial-bus settings memory.
package rss_pkg;

  // Widths of the word fields on the bus side.
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned DEV_W    = 2;
  localparam int unsigned CMD_W    = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned DATA_W   = 8;

  // Default configuration.
  localparam int unsigned MEMORY_BYTES_DEF  = 64;
  localparam int unsigned CHANNEL_COUNT_DEF = 3;

  // Device selection codes.
  localparam logic [DEV_W-1:0]  NO_DEVICE   = 2'd3;
  localparam logic [DEV_W-1:0]  MEM_DEVICE  = 2'd1;
  localparam logic [CHAN_W-1:0] MEM_CHANNEL = 2'd0;

  // Command decode.
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned OFF_SHIFT  = 6;
  localparam logic [ADDR_W-1:0] MEM_BASE = 24'h000100;

  // Reset contents of the settings memory: all zero but one byte.
  localparam int unsigned      DEFAULT_BYTE  = 19;
  localparam logic [DATA_W-1:0] DEFAULT_VALUE = 8'h04;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SELECT   = 3'd0,
    OP_DESELECT = 3'd1,
    OP_COMMAND  = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4
  } opcode_t;

endpackage

// File: sv/rss_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
interface rss_in_if
  import rss_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAN_W-1:0]   channel;
  logic [DEV_W-1:0]    device_number;
  logic [CMD_W-1:0]    command_word;
  logic [INDEX_W-1:0]  byte_index;
  logic [DATA_W-1:0]   data_in;

  modport source (output valid, opcode, channel, device_number, command_word,
                  byte_index, data_in, input ready);
  modport sink   (input valid, opcode, channel, device_number, command_word,
                  byte_index, data_in, output ready);
endinterface

interface rss_out_if
  import rss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              byte_hit;
  logic              save_request;

  modport source (output valid, read_data, byte_hit, save_request, input ready);
  modport sink   (input valid, read_data, byte_hit, save_request, output ready);
endinterface

// File: sv/rtc_sram_serial_device.sv
// Top level of the serial-bus settings memory.
//
// Each input word is one bus access (select, deselect, command word, data
// write or data read) and gives exactly one result word. The settings bytes
// live in a synchronous single-port style memory with a registered read; a
// per-byte valid flag, cleared by reset, makes an unwritten byte read as its
// reset value (zero, or 0x04 for byte 19), so no clearing pass is needed and
// the block accepts words straight out of reset. An access is decoded and its
// write or read issued in the cycle it is accepted; the read data is
// registered in the read stage and the result then in the output register.
// One access is accepted every cycle while the output is drained; the pace
// is set by the one memory port, which serves one byte per cycle. A write
// updates the memory at the edge on which it is accepted, so a read accepted
// in the next cycle already sees it.
module rtc_sram_serial_device
  import rss_pkg::*;
#(
  parameter int unsigned MEMORY_BYTES  = MEMORY_BYTES_DEF,
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rss_in_if.sink   in_ch,
  rss_out_if.source out_ch
);

  localparam int unsigned MEM_AW  = $clog2(MEMORY_BYTES);
  localparam int unsigned OFF_W   = $clog2(MEMORY_BYTES + 1);
  localparam int unsigned POS_W   = ((OFF_W > INDEX_W) ? OFF_W : INDEX_W) + 1;
  localparam int unsigned SHIFT_W = ADDR_W - OFF_SHIFT;

  // Bus state: the selected device of each channel and the byte offset set
  // by the last command word to the selected memory device.
  logic [DEV_W-1:0] sel_dev_r [CHANNEL_COUNT];
  logic [OFF_W-1:0] offset_r;
  logic [OFF_W-1:0] offset_nxt;

  // Settings memory and its written flags.
  logic [DATA_W-1:0]       mem [MEMORY_BYTES];
  logic [MEMORY_BYTES-1:0] written_r;

  // Read stage.
  logic              s1_valid_r;
  logic              s1_hit_r;
  logic              s1_save_r;
  logic              s1_read_r;
  logic [MEM_AW-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_written_r;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_hit_r;
  logic              out_save_r;

  logic              accept;
  logic              advance;
  logic              mem_sel;
  logic [POS_W-1:0]  pos;
  logic              in_range;
  logic              is_write;
  logic              is_read;
  logic              hit;
  logic [MEM_AW-1:0] mem_addr;
  logic [ADDR_W-1:0] cmd_addr;
  logic [ADDR_W-1:0] cmd_rel;
  logic [SHIFT_W-1:0] cmd_off;
  logic [DATA_W-1:0] rd_byte;

  // The read stage moves on when the output register is free or being taken;
  // a new word enters when the read stage is empty or moving on.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;

  assign mem_sel  = (in_ch.channel == MEM_CHANNEL) &&
                    (sel_dev_r[MEM_CHANNEL] == MEM_DEVICE);
  assign pos      = POS_W'(offset_r) + POS_W'(in_ch.byte_index);
  assign in_range = pos < POS_W'(MEMORY_BYTES);
  assign mem_addr = pos[MEM_AW-1:0];
  assign is_write = in_ch.opcode == OP_WRITE;
  assign is_read  = in_ch.opcode == OP_READ;
  assign hit      = mem_sel && in_range && (is_write || is_read);

  // Command word decode: offset in 64-byte steps above the base address,
  // saturated to "no byte" below the base or past the end of the memory.
  assign cmd_addr = in_ch.command_word[ADDR_W-1:0];
  assign cmd_rel  = cmd_addr - MEM_BASE;
  assign cmd_off  = cmd_rel[ADDR_W-1:OFF_SHIFT];

  always_comb begin
    offset_nxt = offset_r;
    if (accept && (in_ch.opcode == OP_COMMAND) && mem_sel) begin
      if (cmd_addr < MEM_BASE || cmd_off >= SHIFT_W'(MEMORY_BYTES)) begin
        offset_nxt = OFF_W'(MEMORY_BYTES);
      end else begin
        offset_nxt = cmd_off[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFF_W'(MEMORY_BYTES);
    end else begin
      offset_r <= offset_nxt;
    end
  end

  // Device selection per channel; accesses to absent channels match no entry.
  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sel_dev_r[c] <= NO_DEVICE;
      end else if (accept && in_ch.channel == CHAN_W'(c)) begin
        if (in_ch.opcode == OP_SELECT) begin
          sel_dev_r[c] <= in_ch.device_number;
        end else if (in_ch.opcode == OP_DESELECT) begin
          sel_dev_r[c] <= NO_DEVICE;
        end
      end
    end
  end

  // Memory port: write and read at the decoded address.
  always_ff @(posedge clk) begin
    if (accept && hit && is_write) begin
      mem[mem_addr] <= in_ch.data_in;
    end
    if (accept) begin
      s1_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (accept && hit && is_write) begin
      written_r[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r     <= hit;
      s1_save_r    <= hit && is_write;
      s1_read_r    <= hit && is_read;
      s1_addr_r    <= mem_addr;
      s1_written_r <= written_r[mem_addr];
    end
  end

  // A byte never written since reset reads as its reset value. The default
  // byte only exists when the memory is large enough to hold it.
  always_comb begin
    if (!s1_read_r) begin
      rd_byte = '0;
    end else if (s1_written_r) begin
      rd_byte = s1_data_r;
    end else if ((DEFAULT_BYTE < MEMORY_BYTES) &&
                 (s1_addr_r == MEM_AW'(DEFAULT_BYTE))) begin
      rd_byte = DEFAULT_VALUE;
    end else begin
      rd_byte = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= rd_byte;
      out_hit_r  <= s1_hit_r;
      out_save_r <= s1_save_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_data_r;
  assign out_ch.byte_hit     = out_hit_r;
  assign out_ch.save_request = out_save_r;

endmodule
